// ----- sv/hevc_config_record_parser_top_macros.svh -----
`ifndef HEVC_CONFIG_RECORD_PARSER_TOP_MACROS_SVH
`define HEVC_CONFIG_RECORD_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define HCRP_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("hcrp check failed");

// next-cycle implication
`define HCRP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("hcrp check failed");

`endif

// ----- sv/hcrp_pkg.sv -----
package hcrp_pkg;

    localparam int HDR_POS_W = 5;

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_ARRAY   = 5'b00010,
        PH_LEN     = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    localparam logic [2:0] ROLE_HEADER  = 3'd0;
    localparam logic [2:0] ROLE_ARRAY   = 3'd1;
    localparam logic [2:0] ROLE_LEN     = 3'd2;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
    localparam logic [2:0] ROLE_IGNORED = 3'd4;

    localparam logic [2:0] ST_BUSY   = 3'd0;
    localparam logic [2:0] ST_DONE   = 3'd1;
    localparam logic [2:0] ST_SHORT  = 3'd2;
    localparam logic [2:0] ST_BADLEN = 3'd3;
    localparam logic [2:0] ST_TRUNC  = 3'd4;

    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_VPS   = 2'd1;
    localparam logic [1:0] CLS_SPS   = 2'd2;
    localparam logic [1:0] CLS_PPS   = 2'd3;

    localparam logic [5:0] TYPE_VPS = 6'd32;
    localparam logic [5:0] TYPE_SPS = 6'd33;
    localparam logic [5:0] TYPE_PPS = 6'd34;

    localparam logic [1:0] LEN_SIZE_BAD = 2'd2;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  role;
        logic [1:0]  param_class;
        logic        nal_start;
        logic        nal_end;
        logic [2:0]  status;
        logic [1:0]  profile_space;
        logic        tier_flag;
        logic [4:0]  profile_idc;
        logic [7:0]  level_idc;
        logic [1:0]  length_size_minus_one;
        logic [15:0] class_count;
    } result_t;

    function automatic logic [1:0] class_of(input logic [5:0] t);
        logic [1:0] c;
        c = CLS_OTHER;
        if (t == TYPE_VPS) c = CLS_VPS;
        if (t == TYPE_SPS) c = CLS_SPS;
        if (t == TYPE_PPS) c = CLS_PPS;
        return c;
    endfunction

endpackage

// ----- sv/hcrp_parse_core.sv -----
module hcrp_parse_core #(
    parameter int HEADER_BYTES     = 23,
    parameter int CONSTRAINT_BYTES = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output hcrp_pkg::result_t res
);
    import hcrp_pkg::*;

    localparam logic [HDR_POS_W-1:0] POS_PROFILE = HDR_POS_W'(1);
    localparam logic [HDR_POS_W-1:0] POS_LEVEL   = HDR_POS_W'(6 + CONSTRAINT_BYTES);
    localparam logic [HDR_POS_W-1:0] POS_LENSIZE = HDR_POS_W'(HEADER_BYTES - 2);
    localparam logic [HDR_POS_W-1:0] POS_ARRAYS  = HDR_POS_W'(HEADER_BYTES - 1);

    phase_t               phase_reg, phase_next;
    logic [HDR_POS_W-1:0] hpos_reg, hpos_next;
    logic [7:0]           profile_reg, profile_next;
    logic [7:0]           level_reg, level_next;
    logic [1:0]           lsize_reg, lsize_next;
    logic [7:0]           arrays_reg, arrays_next;
    logic [5:0]           atype_reg, atype_next;
    logic [15:0]          sets_reg, sets_next;
    logic [1:0]           fbi_reg, fbi_next;
    logic [15:0]          pay_reg, pay_next;
    logic [2:0]           status_reg, status_next;
    logic [15:0]          vps_reg, vps_next;
    logic [15:0]          sps_reg, sps_next;
    logic [15:0]          pps_reg, pps_next;

    always_comb
    begin
        logic [15:0] tmp16;
        logic [7:0]  tmp8;
        logic        set_done;
        logic        arr_done;
        logic [1:0]  set_cls;

        phase_next   = phase_reg;
        hpos_next    = hpos_reg;
        profile_next = profile_reg;
        level_next   = level_reg;
        lsize_next   = lsize_reg;
        arrays_next  = arrays_reg;
        atype_next   = atype_reg;
        sets_next    = sets_reg;
        fbi_next     = fbi_reg;
        pay_next     = pay_reg;
        status_next  = status_reg;
        vps_next     = vps_reg;
        sps_next     = sps_reg;
        pps_next     = pps_reg;
        set_done     = 1'b0;
        arr_done     = 1'b0;
        tmp16        = 16'h0;
        tmp8         = 8'h0;
        set_cls      = class_of(atype_reg);

        res.out_byte    = in_byte;
        res.role        = ROLE_IGNORED;
        res.param_class = CLS_OTHER;
        res.nal_start   = 1'b0;
        res.nal_end     = 1'b0;
        res.class_count = 16'h0;

        if (status_reg == ST_BUSY)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    res.role = ROLE_HEADER;
                    if (hpos_reg == POS_PROFILE)
                        profile_next = in_byte;
                    if (hpos_reg == POS_LEVEL)
                        level_next = in_byte;
                    if (hpos_reg == POS_LENSIZE)
                    begin
                        lsize_next = in_byte[1:0];
                        if (in_byte[1:0] == LEN_SIZE_BAD)
                            status_next = ST_BADLEN;
                    end
                    if (hpos_reg >= POS_ARRAYS)
                    begin
                        if (status_next == ST_BUSY)
                        begin
                            arrays_next = in_byte;
                            vps_next    = 16'h0;
                            sps_next    = 16'h0;
                            pps_next    = 16'h0;
                            fbi_next    = 2'd0;
                            if (in_byte == 8'h0)
                            begin
                                phase_next  = PH_DONE;
                                status_next = ST_DONE;
                            end
                            else
                            begin
                                phase_next = PH_ARRAY;
                            end
                        end
                    end
                    else
                    begin
                        hpos_next = hpos_reg + HDR_POS_W'(1);
                    end
                end
                PH_ARRAY:
                begin
                    res.role = ROLE_ARRAY;
                    case (fbi_reg)
                        2'd0:
                        begin
                            atype_next = in_byte[5:0];
                            fbi_next   = 2'd1;
                        end
                        2'd1:
                        begin
                            sets_next = {in_byte, 8'h0};
                            fbi_next  = 2'd2;
                        end
                        default:
                        begin
                            tmp16     = sets_reg | {8'h0, in_byte};
                            sets_next = tmp16;
                            fbi_next  = 2'd0;
                            if (tmp16 == 16'h0)
                                arr_done = 1'b1;
                            else
                                phase_next = PH_LEN;
                        end
                    endcase
                end
                PH_LEN:
                begin
                    res.role = ROLE_LEN;
                    if (fbi_reg == 2'd0)
                    begin
                        pay_next = {in_byte, 8'h0};
                        fbi_next = 2'd1;
                    end
                    else
                    begin
                        tmp16    = pay_reg | {8'h0, in_byte};
                        pay_next = tmp16;
                        fbi_next = 2'd0;
                        if (tmp16 == 16'h0)
                            set_done = 1'b1;
                        else
                            phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    res.role      = ROLE_PAYLOAD;
                    res.nal_start = (fbi_reg == 2'd0);
                    fbi_next      = 2'd1;
                    tmp16         = pay_reg - 16'd1;
                    pay_next      = tmp16;
                    if (tmp16 == 16'h0)
                    begin
                        res.nal_end = 1'b1;
                        set_done    = 1'b1;
                    end
                end
                default:
                begin
                    res.role = ROLE_IGNORED;
                end
            endcase

            if (set_done)
            begin
                if (set_cls == CLS_VPS && vps_reg != 16'hFFFF)
                    vps_next = vps_reg + 16'd1;
                if (set_cls == CLS_SPS && sps_reg != 16'hFFFF)
                    sps_next = sps_reg + 16'd1;
                if (set_cls == CLS_PPS && pps_reg != 16'hFFFF)
                    pps_next = pps_reg + 16'd1;
                tmp16     = sets_reg - 16'd1;
                sets_next = tmp16;
                fbi_next  = 2'd0;
                if (tmp16 == 16'h0)
                    arr_done = 1'b1;
                else
                    phase_next = PH_LEN;
            end

            if (arr_done)
            begin
                tmp8        = arrays_reg - 8'd1;
                arrays_next = tmp8;
                fbi_next    = 2'd0;
                if (tmp8 == 8'h0)
                begin
                    phase_next  = PH_DONE;
                    status_next = ST_DONE;
                end
                else
                begin
                    phase_next = PH_ARRAY;
                end
            end

            if (res.role inside {ROLE_ARRAY, ROLE_LEN, ROLE_PAYLOAD})
            begin
                res.param_class = class_of(atype_next);
                case (res.param_class)
                    CLS_VPS: res.class_count = vps_next;
                    CLS_SPS: res.class_count = sps_next;
                    CLS_PPS: res.class_count = pps_next;
                    default: res.class_count = 16'h0;
                endcase
            end

            if (in_last && status_next == ST_BUSY)
                status_next = (phase_next == PH_HEADER) ? ST_SHORT : ST_TRUNC;
        end

        res.status                = status_next;
        res.profile_space         = profile_next[7:6];
        res.tier_flag             = profile_next[5];
        res.profile_idc           = profile_next[4:0];
        res.level_idc             = level_next;
        res.length_size_minus_one = lsize_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hpos_reg    <= '0;
            profile_reg <= 8'h0;
            level_reg   <= 8'h0;
            lsize_reg   <= 2'd0;
            arrays_reg  <= 8'h0;
            atype_reg   <= 6'h0;
            sets_reg    <= 16'h0;
            fbi_reg     <= 2'd0;
            pay_reg     <= 16'h0;
            status_reg  <= ST_BUSY;
            vps_reg     <= 16'h0;
            sps_reg     <= 16'h0;
            pps_reg     <= 16'h0;
        end
        else if (step)
        begin
            profile_reg <= profile_next;
            level_reg   <= level_next;
            lsize_reg   <= lsize_next;
            vps_reg     <= vps_next;
            sps_reg     <= sps_next;
            pps_reg     <= pps_next;
            if (in_last)
            begin
                // restart parse, keep header fields and counts
                phase_reg  <= PH_HEADER;
                hpos_reg   <= '0;
                arrays_reg <= 8'h0;
                atype_reg  <= 6'h0;
                sets_reg   <= 16'h0;
                fbi_reg    <= 2'd0;
                pay_reg    <= 16'h0;
                status_reg <= ST_BUSY;
            end
            else
            begin
                phase_reg  <= phase_next;
                hpos_reg   <= hpos_next;
                arrays_reg <= arrays_next;
                atype_reg  <= atype_next;
                sets_reg   <= sets_next;
                fbi_reg    <= fbi_next;
                pay_reg    <= pay_next;
                status_reg <= status_next;
            end
        end
    end

endmodule

// ----- sv/hevc_config_record_parser_top.sv -----
// HEVC decoder configuration record parser. Feed the record one byte per item on the
// slave side, with tlast on the final byte of the buffer; every input byte yields exactly
// one result item on the master side, tagged with its role, parameter set class and
// nal start/end, plus the decoded header fields, running class count and status.
// Throughput is one byte per clock while the master side accepts results: the whole
// parse-state update for a byte is combinational between the input register and the
// output register. An accepted byte waits in the input register until its result is
// taken into the output register. Errors stay sticky until the last byte, after which
// the parser restarts for the next record; header fields and class counts are kept.
module hevc_config_record_parser_top #(
    parameter int HEADER_BYTES     = 23,
    parameter int CONSTRAINT_BYTES = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_byte, [10:8] status, [12:11] profile_space, [13] tier_flag,
    // [18:14] profile_idc, [26:19] level_idc, [28:27] length_size_minus_one,
    // [44:29] class_count, [47:45] zero
    output logic [47:0] m_axis_tdata,
    // [2:0] role, [4:3] param_class, [5] nal_start
    output logic [5:0]  m_axis_tuser,
    output logic        m_axis_tlast    // nal_end
);
    import hcrp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg;
    result_t    res;
    logic       advance;
    logic       s_accept;
    logic       m_accept;

    assign advance        = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !in_valid_reg || advance;
    assign s_accept       = s_axis_tvalid && s_axis_tready;
    assign m_accept       = out_valid_reg && m_axis_tready;
    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_accept ? 1'b0 : out_valid_reg);

    hcrp_parse_core #(
        .HEADER_BYTES     (HEADER_BYTES),
        .CONSTRAINT_BYTES (CONSTRAINT_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            out_res_reg.class_count,
                            out_res_reg.length_size_minus_one,
                            out_res_reg.level_idc,
                            out_res_reg.profile_idc,
                            out_res_reg.tier_flag,
                            out_res_reg.profile_space,
                            out_res_reg.status,
                            out_res_reg.out_byte};
    assign m_axis_tuser  = {out_res_reg.nal_start, out_res_reg.param_class, out_res_reg.role};
    assign m_axis_tlast  = out_res_reg.nal_end;

endmodule

// ----- sv/hcrp_checker.sv -----
`include "hevc_config_record_parser_top_macros.svh"

module hcrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [5:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import hcrp_pkg::*;

    logic [2:0]  role;
    logic [1:0]  pclass;
    logic [2:0]  status;
    logic [15:0] ccount;
    logic        in_seen;

    assign role    = m_axis_tuser[2:0];
    assign pclass  = m_axis_tuser[4:3];
    assign status  = m_axis_tdata[10:8];
    assign ccount  = m_axis_tdata[44:29];
    assign in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata != 8'h0 || s_axis_tlast);

    `HCRP_ASSERT_NOW(a_nal_marks_payload, clk, rst_n, m_axis_tvalid && (m_axis_tuser[5] || m_axis_tlast), role == ROLE_PAYLOAD)
    `HCRP_ASSERT_NOW(a_no_count_outside_arrays, clk, rst_n, m_axis_tvalid && (role == ROLE_HEADER || role == ROLE_IGNORED), ccount == 16'h0 && pclass == CLS_OTHER)
    `HCRP_ASSERT_NOW(a_ignored_not_busy, clk, rst_n, m_axis_tvalid && role == ROLE_IGNORED, status != ST_BUSY)
    `HCRP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready && !in_seen, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind hevc_config_record_parser_top hcrp_checker u_hcrp_checker (.*);
